// ----- rtl/urmt_pkg.sv -----
// shared types and constants for the range match table
package urmt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int VALUE_BITS  = 32;
	localparam int LABEL_BITS  = 32;
	localparam int FIELD_BITS  = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_NONE     = 2'd0,
		STAT_UNIQUE   = 2'd1,
		STAT_MULTIPLE = 2'd2
	} status_t;

	// word moving down the cell chain: a load or a query
	typedef struct packed {
		logic                  vld;
		logic                  is_load;
		logic [IDX_W-1:0]      idx;
		logic [CNT_W-1:0]      cnt;
		logic [VALUE_BITS-1:0] lo;
		logic [VALUE_BITS-1:0] hi;
		logic [LABEL_BITS-1:0] label;
		status_t               hits;
	} tok_t;

endpackage

// ----- rtl/urmt_cell.sv -----
// one table entry: stores a range on a matching load, checks passing queries
module urmt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [urmt_pkg::IDX_W-1:0]   cell_idx,
	input  urmt_pkg::tok_t               tok_in,
	output urmt_pkg::tok_t               tok_out
);

	logic [urmt_pkg::VALUE_BITS-1:0] lo_q;
	logic [urmt_pkg::VALUE_BITS-1:0] hi_q;
	logic [urmt_pkg::LABEL_BITS-1:0] label_q;
	urmt_pkg::tok_t                  tok_n;
	urmt_pkg::tok_t                  tok_q;
	logic                            wr;
	logic                            hit;

	assign wr = tok_in.vld && tok_in.is_load && (tok_in.idx == cell_idx);

	// entry storage, written when its load word passes
	always_ff @(posedge clk) begin
		if (wr) begin
			lo_q    <= tok_in.lo;
			hi_q    <= tok_in.hi;
			label_q <= tok_in.label;
		end
	end

	// range check against this entry when it was loaded before the query
	assign hit = tok_in.vld && !tok_in.is_load
		&& (urmt_pkg::CNT_W'(cell_idx) < tok_in.cnt)
		&& (tok_in.lo >= lo_q) && (tok_in.lo <= hi_q);

	always_comb begin
		tok_n = tok_in;
		if (hit) begin
			tok_n.label = label_q;
			if (tok_in.hits == urmt_pkg::STAT_NONE) begin
				tok_n.hits = urmt_pkg::STAT_UNIQUE;
			end else begin
				tok_n.hits = urmt_pkg::STAT_MULTIPLE;
			end
		end
	end

	// hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_n;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- rtl/unique_range_match_table.sv -----
// range match table: a chain of MAX_ENTRIES cells, one entry per cell
// a query result strobes on done once the word has passed every cell register and then the result register
// throughput: one word per cycle; loads and queries flow down the chain in order
// busy stays low and the receiver cannot stall; clears act at once on the entry count
// reset clears the entry count and all in-flight words; entry contents are
// undefined until loaded
module unique_range_match_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic [urmt_pkg::FIELD_BITS-1:0]  range_low,
	input  logic [urmt_pkg::FIELD_BITS-1:0]  range_high,
	input  logic [urmt_pkg::FIELD_BITS-1:0]  entry_label,
	input  logic [urmt_pkg::FIELD_BITS-1:0]  query_value,
	output logic                             done,
	output logic [1:0]                       match_status,
	output logic [urmt_pkg::LABEL_BITS-1:0]  match_label
);

	urmt_pkg::tok_t                chain [0:urmt_pkg::MAX_ENTRIES];
	logic [urmt_pkg::CNT_W-1:0]    count_q;
	logic                          accept;
	logic                          full;
	urmt_pkg::op_t                 op_in;
	urmt_pkg::tok_t                last;
	logic                          done_q;
	urmt_pkg::status_t             status_q;
	logic [urmt_pkg::LABEL_BITS-1:0] label_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op_in  = urmt_pkg::op_t'(op);
	assign full   = (count_q == urmt_pkg::CNT_W'(urmt_pkg::MAX_ENTRIES));

	// entry count: clear resets, load appends until full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			case (op_in)
				urmt_pkg::OP_CLEAR: count_q <= '0;
				urmt_pkg::OP_LOAD: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: count_q <= count_q;
			endcase
		end
	end

	// build the word entering the chain
	always_comb begin
		chain[0].vld     = 1'b0;
		chain[0].is_load = 1'b0;
		chain[0].idx     = count_q[urmt_pkg::IDX_W-1:0];
		chain[0].cnt     = count_q;
		chain[0].lo      = urmt_pkg::VALUE_BITS'(range_low);
		chain[0].hi      = urmt_pkg::VALUE_BITS'(range_high);
		chain[0].label   = entry_label;
		chain[0].hits    = urmt_pkg::STAT_NONE;
		case (op_in)
			urmt_pkg::OP_LOAD: begin
				chain[0].vld     = accept && !full;
				chain[0].is_load = 1'b1;
			end
			urmt_pkg::OP_QUERY: begin
				chain[0].vld = accept;
				chain[0].lo  = urmt_pkg::VALUE_BITS'(query_value);
			end
			default: chain[0].vld = 1'b0;
		endcase
	end

	// row of cells, one per entry
	for (genvar k = 0; k < urmt_pkg::MAX_ENTRIES; k++) begin : g_cell
		urmt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(urmt_pkg::IDX_W'(k)),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	assign last = chain[urmt_pkg::MAX_ENTRIES];

	// result register at the chain tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.vld && !last.is_load;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= last.hits;
		if (last.hits == urmt_pkg::STAT_UNIQUE) begin
			label_q <= last.label;
		end else begin
			label_q <= '0;
		end
	end

	assign done         = done_q;
	assign match_status = status_q;
	assign match_label  = label_q;

endmodule

// ----- dv/unique_range_match_table_tb.sv -----
// testbench for the range match table: directed, table-full and random word streams
module unique_range_match_table_tb;
	import urmt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RESULT_LAT  = MAX_ENTRIES + 1;
	localparam logic [FIELD_BITS-1:0] ALL_ONES = '1;

	typedef struct packed {
		status_t               status;
		logic [LABEL_BITS-1:0] label;
	} match_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	logic [1:0]            op          = OP_NONE;
	logic [FIELD_BITS-1:0] range_low   = '0;
	logic [FIELD_BITS-1:0] range_high  = '0;
	logic [FIELD_BITS-1:0] entry_label = '0;
	logic [FIELD_BITS-1:0] query_value = '0;
	logic                  done;
	logic [1:0]            match_status;
	logic [LABEL_BITS-1:0] match_label;

	// shadow copy of the range table
	logic [VALUE_BITS-1:0] tbl_lo    [MAX_ENTRIES];
	logic [VALUE_BITS-1:0] tbl_hi    [MAX_ENTRIES];
	logic [LABEL_BITS-1:0] tbl_label [MAX_ENTRIES];
	int unsigned           tbl_count = 0;

	match_t match_q[$];
	int     send_idle_pct = 0;
	int     words_sent    = 0;
	int     fail_cnt      = 0;
	int     cycle_cnt     = 0;

	unique_range_match_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.range_low    (range_low),
		.range_high   (range_high),
		.entry_label  (entry_label),
		.query_value  (query_value),
		.done         (done),
		.match_status (match_status),
		.match_label  (match_label)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, match_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void flag_error(string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("ERROR @%0d: %s", cycle_cnt, msg);
	endfunction

	// apply one accepted word to the shadow table, queue the match for a query
	function automatic void table_apply(op_t o, logic [FIELD_BITS-1:0] lo,
			logic [FIELD_BITS-1:0] hi, logic [FIELD_BITS-1:0] lbl,
			logic [FIELD_BITS-1:0] qv);
		int                    hits      = 0;
		logic [LABEL_BITS-1:0] hit_label = '0;
		logic [VALUE_BITS-1:0] x;
		match_t                m;
		x = qv[VALUE_BITS-1:0];
		case (o)
			OP_CLEAR: tbl_count = 0;
			OP_LOAD: begin
				if (tbl_count < MAX_ENTRIES) begin
					tbl_lo[tbl_count]    = lo[VALUE_BITS-1:0];
					tbl_hi[tbl_count]    = hi[VALUE_BITS-1:0];
					tbl_label[tbl_count] = lbl[LABEL_BITS-1:0];
					tbl_count++;
				end
			end
			OP_QUERY: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (x >= tbl_lo[i] && x <= tbl_hi[i]) begin
						if (hits < 2)
							hits++;
						hit_label = tbl_label[i];
					end
				end
				m.label = '0;
				if (hits == 0) begin
					m.status = STAT_NONE;
				end else if (hits == 1) begin
					m.status = STAT_UNIQUE;
					m.label  = hit_label;
				end else begin
					m.status = STAT_MULTIPLE;
				end
				match_q = {match_q, m};
			end
			default: ;
		endcase
	endfunction

	// send one word, with random idle cycles ahead of it
	task automatic send_word(op_t o, logic [FIELD_BITS-1:0] lo, logic [FIELD_BITS-1:0] hi,
			logic [FIELD_BITS-1:0] lbl, logic [FIELD_BITS-1:0] qv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		op          <= o;
		range_low   <= lo;
		range_high  <= hi;
		entry_label <= lbl;
		query_value <= qv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		table_apply(o, lo, hi, lbl, qv);
		if (o != OP_NONE)
			words_sent++;
	endtask

	// unused fields of each op carry random junk
	task automatic clear_table();
		send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic load_entry(logic [FIELD_BITS-1:0] lo, logic [FIELD_BITS-1:0] hi,
			logic [FIELD_BITS-1:0] lbl);
		send_word(OP_LOAD, lo, hi, lbl, $urandom);
	endtask

	task automatic query_at(logic [FIELD_BITS-1:0] qv);
		send_word(OP_QUERY, $urandom, $urandom, $urandom, qv);
	endtask

	task automatic send_unused();
		send_word(OP_NONE, $urandom, $urandom, $urandom, $urandom);
	endtask

	// mostly narrow ranges in a window so that they overlap, some wide or inverted
	function automatic void make_range(logic [FIELD_BITS-1:0] base,
			output logic [FIELD_BITS-1:0] lo, output logic [FIELD_BITS-1:0] hi);
		logic [FIELD_BITS-1:0] t;
		case ($urandom_range(0, 19))
			0: begin
				lo = $urandom;
				hi = $urandom;
			end
			1: begin
				lo = '0;
				hi = ALL_ONES;
			end
			default: begin
				lo = base + $urandom_range(0, 47);
				hi = lo + $urandom_range(0, 15);
			end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			t  = lo;
			lo = hi;
			hi = t;
		end
	endfunction

	// query values at, just outside and midway between loaded bounds, or random ones
	function automatic logic [FIELD_BITS-1:0] pick_query(logic [FIELD_BITS-1:0] base);
		int unsigned k;
		if (tbl_count == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? $urandom : base + $urandom_range(0, 63);
		k = $urandom_range(0, tbl_count - 1);
		case ($urandom_range(0, 4))
			0: return tbl_lo[k];
			1: return tbl_hi[k];
			2: return tbl_lo[k] - 1;
			3: return tbl_hi[k] + 1;
			default: return tbl_lo[k] + ((tbl_hi[k] - tbl_lo[k]) >> 1);
		endcase
	endfunction

	// result checker: done is a one-cycle strobe, no backpressure
	always @(posedge clk) begin : check_result
		match_t m;
		if (arst_n && done) begin
			if (match_q.size() == 0) begin
				flag_error($sformatf("unexpected result: status %0d label %h",
					match_status, match_label));
			end else begin
				m = match_q.pop_front();
				if (match_status !== m.status)
					flag_error($sformatf("match_status: expected %0d, got %0d",
						m.status, match_status));
				if (match_label !== m.label)
					flag_error($sformatf("match_label: expected %h, got %h",
						m.label, match_label));
			end
		end
	end

	// bounds at the extremes, overlaps, inverted range, empty table, unused op
	task automatic test_directed();
		query_at('0);
		send_unused();
		load_entry('0, '0, 32'h0000_00a5);
		load_entry(ALL_ONES, ALL_ONES, ALL_ONES);
		load_entry(32'd100, 32'd200, 32'h0000_1234);
		load_entry(32'd300, 32'd250, 32'd5);
		load_entry(32'd150, 32'd400, 32'd7);
		query_at('0);
		query_at(ALL_ONES);
		query_at(32'd100);
		query_at(32'd99);
		query_at(32'd150);
		query_at(32'd200);
		query_at(32'd201);
		query_at(32'd260);
		query_at(32'd401);
		query_at(32'd1);
		send_unused();
		query_at(32'd175);
		clear_table();
		query_at('0);
		load_entry('0, ALL_ONES, '0);
		query_at($urandom);
		query_at(ALL_ONES);
	endtask

	// fill every slot, then loads past capacity must be dropped
	task automatic test_table_full();
		clear_table();
		for (int i = 0; i < MAX_ENTRIES; i++)
			load_entry(2 * i, 2 * i, i);
		repeat (3)
			load_entry('0, ALL_ONES, $urandom);
		query_at('0);
		query_at(2 * (MAX_ENTRIES - 1));
		query_at(32'd1);
		query_at(2 * MAX_ENTRIES);
		query_at(ALL_ONES);
		clear_table();
		query_at('0);
	endtask

	// random sequences: a clear in most rounds, a batch of loads, then queries mixed with some noise
	task automatic test_random(int idle_pct, int n_words);
		int                    target;
		int                    n_loads;
		logic [FIELD_BITS-1:0] base;
		logic [FIELD_BITS-1:0] lo;
		logic [FIELD_BITS-1:0] hi;
		send_idle_pct = idle_pct;
		target = words_sent + n_words;
		while (words_sent < target) begin
			if ($urandom_range(0, 9) < 8)
				clear_table();
			case ($urandom_range(0, 3))
				0: base = '0;
				1: base = ALL_ONES - 63;
				default: base = $urandom;
			endcase
			if ($urandom_range(0, 9) == 0)
				n_loads = $urandom_range(MAX_ENTRIES - 4, MAX_ENTRIES + 6);
			else
				n_loads = $urandom_range(0, 8);
			repeat (n_loads) begin
				make_range(base, lo, hi);
				load_entry(lo, hi, $urandom);
			end
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 19))
					0: send_unused();
					1: begin
						make_range(base, lo, hi);
						load_entry(lo, hi, $urandom);
					end
					default: query_at(pick_query(base));
				endcase
			end
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 6;
		test_directed();
		test_table_full();
		test_random(6, 480);
		test_random(54, 480);
		test_random(0, 450);
		start <= 1'b0;
		// drain outstanding queries, then watch for stray results
		while (match_q.size() != 0)
			@(posedge clk);
		repeat (RESULT_LAT + 4)
			@(posedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/urmt_pkg.sv
rtl/urmt_cell.sv
rtl/unique_range_match_table.sv
dv/unique_range_match_table_tb.sv
